/* hw/rtl/spf_pkg.sv */
// ============================================================================
// spf_pkg
// Shared types and constants of the smallest-prime-factor factorizer.
// ============================================================================
package spf_pkg;

    // Width of a table entry, a queried value and a factor
    localparam int VAL_W = 16;

    // Width of the sieving prime counter; sieving stops once i*i passes the
    // bound, so i never exceeds 256 for a 16-bit bound
    localparam int SIEVE_W = 9;

    // Input command codes
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_FACTOR   = 3'd0,
        STAT_NONE     = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOTBUILT = 3'd3,
        STAT_DONE     = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SV_RD,
        ST_SV_CHK,
        ST_SV_J,
        ST_BLD_DONE,
        ST_EMIT1,
        ST_Q_RD,
        ST_Q_WAIT,
        ST_Q_DIV,
        ST_Q_EMIT
    } state_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* hw/rtl/spf_ram.sv */
// ============================================================================
// spf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module spf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/spf_div.sv */
// ============================================================================
// spf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module spf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [spf_pkg::VAL_W-1:0] dividend,
    input  logic [spf_pkg::VAL_W-1:0] divisor,
    output logic [spf_pkg::VAL_W-1:0] quotient,
    output spf_pkg::div_stat_t        stat
);

    localparam int VW = spf_pkg::VAL_W;
    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0] q_reg, q_next;
    logic [VW:0]   r_reg, r_next;
    logic [VW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;

    // One restoring step per cycle
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[VW-1:0], q_reg[VW-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(VW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, d_reg}) begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[VW-2:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[VW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hw/rtl/smallest_prime_factor_factorizer.sv */
// ============================================================================
// smallest_prime_factor_factorizer
// Smallest-prime-factor table in block RAM with build and factor-query items.
// ============================================================================
// A build item (command 0) takes bound = min(limit, TABLE_DEPTH-1), writes
// every entry 0..bound with its own index, then sieves: each candidate i
// with i*i <= bound gets a table read and a check, and each prime then
// steps through its multiples from i*i to bound, one multiple per cycle,
// reading each and rewriting it with i through a pipeline register if
// still unmarked; the build ends in a single build-done result. A factor
// query is decided first and then, for each factor, runs a table read, a
// serial divide and an emit; 32768 gives fifteen factors. Rejected queries
// (no table yet, value 0 or 1, value above the bound) give one result. The
// single RAM read port and the serial divider set the pace. Items are taken
// one at a time; the next item can be accepted while the previous final
// result still waits on the output. The table contents are undefined after
// reset; queries are rejected until a build completes.
// ============================================================================
module smallest_prime_factor_factorizer #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_value,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_factor,
    output logic [2:0]  m_status,
    output logic        m_last,
    // limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int VW = spf_pkg::VAL_W;
    localparam int IW = spf_pkg::SIEVE_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [VW-1:0] MAX_BOUND =
        VW'((TABLE_DEPTH - 1 > 65535) ? 65535 : TABLE_DEPTH - 1);

    spf_pkg::state_t    state_reg, state_next;
    logic [VW-1:0]      limit_reg, limit_next;
    logic               table_valid_reg, table_valid_next;
    logic [VW-1:0]      built_bound_reg, built_bound_next;
    logic [VW-1:0]      bound_reg, bound_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [VW:0]        sq_reg, sq_next;
    logic [VW:0]        j_reg, j_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [VW-1:0]      pend_j_reg, pend_j_next;
    logic [VW-1:0]      rem_reg, rem_next;
    logic [VW-1:0]      p_reg, p_next;
    spf_pkg::status_t   stat_reg, stat_next;

    logic               m_valid_reg, m_valid_next;
    logic [VW-1:0]      m_factor_reg, m_factor_next;
    spf_pkg::status_t   m_status_reg, m_status_next;
    logic               m_last_reg, m_last_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VW-1:0]      ram_wdata, ram_rdata;

    logic               div_start;
    logic [VW-1:0]      div_quot;
    spf_pkg::div_stat_t div_stat;

    logic               slot_free;
    logic               j_in;
    logic               rd_is_prime;
    logic               q_reject;
    logic [VW-1:0]      q_bound;
    logic [VW-1:0]      i_wide;
    logic [VW-1:0]      p_pick;

    spf_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (p_pick),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Shared decode terms
    assign slot_free   = !m_valid_reg || m_ready;
    assign j_in        = j_reg <= {1'b0, bound_reg};
    assign i_wide      = {{(VW - IW){1'b0}}, i_reg};
    assign rd_is_prime = ram_rdata == i_wide;
    assign q_bound     = (built_bound_reg < limit_reg) ? built_bound_reg : limit_reg;
    assign q_reject    = !table_valid_reg || (s_value <= VW'(1)) || (s_value > q_bound);
    assign p_pick      = (ram_rdata < VW'(2)) ? rem_reg : ram_rdata;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == spf_pkg::CMD_BUILD) begin
                        state_next = spf_pkg::ST_INIT;
                    end else if (q_reject) begin
                        state_next = spf_pkg::ST_EMIT1;
                    end else begin
                        state_next = spf_pkg::ST_Q_RD;
                    end
                end
            end
            spf_pkg::ST_INIT: begin
                if (j_reg == {1'b0, bound_reg}) begin
                    state_next = spf_pkg::ST_SV_RD;
                end
            end
            spf_pkg::ST_SV_RD: begin
                if (sq_reg > {1'b0, bound_reg}) begin
                    state_next = spf_pkg::ST_BLD_DONE;
                end else begin
                    state_next = spf_pkg::ST_SV_CHK;
                end
            end
            spf_pkg::ST_SV_CHK: begin
                state_next = rd_is_prime ? spf_pkg::ST_SV_J : spf_pkg::ST_SV_RD;
            end
            spf_pkg::ST_SV_J: begin
                if (!j_in && !pend_valid_reg) begin
                    state_next = spf_pkg::ST_SV_RD;
                end
            end
            spf_pkg::ST_BLD_DONE,
            spf_pkg::ST_EMIT1: begin
                if (slot_free) begin
                    state_next = spf_pkg::ST_IDLE;
                end
            end
            spf_pkg::ST_Q_RD:   state_next = spf_pkg::ST_Q_WAIT;
            spf_pkg::ST_Q_WAIT: state_next = spf_pkg::ST_Q_DIV;
            spf_pkg::ST_Q_DIV: begin
                if (div_stat.done) begin
                    state_next = spf_pkg::ST_Q_EMIT;
                end
            end
            spf_pkg::ST_Q_EMIT: begin
                if (slot_free) begin
                    state_next = (rem_reg <= VW'(1)) ? spf_pkg::ST_IDLE : spf_pkg::ST_Q_RD;
                end
            end
            default: state_next = spf_pkg::ST_IDLE;
        endcase
    end

    // Datapath, RAM access and result register
    always_comb begin
        limit_next       = cfg_valid ? cfg_data : limit_reg;
        table_valid_next = table_valid_reg;
        built_bound_next = built_bound_reg;
        bound_next       = bound_reg;
        i_next           = i_reg;
        sq_next          = sq_reg;
        j_next           = j_reg;
        pend_valid_next  = pend_valid_reg;
        pend_j_next      = pend_j_reg;
        rem_next         = rem_reg;
        p_next           = p_reg;
        stat_next        = stat_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_factor_next    = m_factor_reg;
        m_status_next    = m_status_reg;
        m_last_next      = m_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(j_reg);
        ram_wdata        = j_reg[VW-1:0];
        ram_re           = 1'b0;
        ram_raddr        = AW'(i_reg);
        div_start        = 1'b0;

        unique case (state_reg)
            spf_pkg::ST_IDLE: begin
                // Decode the item and pick its first step
                if (s_valid) begin
                    rem_next = s_value;
                    if (s_command == spf_pkg::CMD_BUILD) begin
                        bound_next = (limit_reg > MAX_BOUND) ? MAX_BOUND : limit_reg;
                        j_next     = '0;
                    end else if (!table_valid_reg) begin
                        stat_next = spf_pkg::STAT_NOTBUILT;
                    end else if (s_value <= VW'(1)) begin
                        stat_next = spf_pkg::STAT_NONE;
                    end else begin
                        stat_next = spf_pkg::STAT_RANGE;
                    end
                end
            end
            spf_pkg::ST_INIT: begin
                // Write each entry with its own index
                ram_we = 1'b1;
                j_next = j_reg + (VW + 1)'(1);
                if (j_reg == {1'b0, bound_reg}) begin
                    i_next  = IW'(2);
                    sq_next = (VW + 1)'(4);
                end
            end
            spf_pkg::ST_SV_RD: begin
                // Fetch the candidate entry
                ram_re = sq_reg <= {1'b0, bound_reg};
            end
            spf_pkg::ST_SV_CHK: begin
                // Prime: start marking at i*i; otherwise advance
                pend_valid_next = 1'b0;
                if (rd_is_prime) begin
                    j_next = sq_reg;
                end else begin
                    i_next  = i_reg + IW'(1);
                    sq_next = sq_reg + (VW + 1)'({i_reg, 1'b1});
                end
            end
            spf_pkg::ST_SV_J: begin
                // Read the next multiple, rewrite the previous one if unmarked
                if (j_in) begin
                    ram_re          = 1'b1;
                    ram_raddr       = AW'(j_reg);
                    pend_valid_next = 1'b1;
                    pend_j_next     = j_reg[VW-1:0];
                    j_next          = j_reg + (VW + 1)'(i_reg);
                end else begin
                    pend_valid_next = 1'b0;
                end
                if (pend_valid_reg && (ram_rdata == pend_j_reg)) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(pend_j_reg);
                    ram_wdata = i_wide;
                end
                if (!j_in && !pend_valid_reg) begin
                    i_next  = i_reg + IW'(1);
                    sq_next = sq_reg + (VW + 1)'({i_reg, 1'b1});
                end
            end
            spf_pkg::ST_BLD_DONE: begin
                // Publish the table and report the build
                if (slot_free) begin
                    built_bound_next = bound_reg;
                    table_valid_next = 1'b1;
                    m_valid_next     = 1'b1;
                    m_factor_next    = '0;
                    m_status_next    = spf_pkg::STAT_DONE;
                    m_last_next      = 1'b1;
                end
            end
            spf_pkg::ST_EMIT1: begin
                // Report a rejected or trivial query
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_factor_next = '0;
                    m_status_next = stat_reg;
                    m_last_next   = 1'b1;
                end
            end
            spf_pkg::ST_Q_RD: begin
                // Look up the smallest factor of what remains
                ram_re    = 1'b1;
                ram_raddr = AW'(rem_reg);
            end
            spf_pkg::ST_Q_WAIT: begin
                // Hold the factor and divide it out
                p_next    = p_pick;
                div_start = 1'b1;
            end
            spf_pkg::ST_Q_DIV: begin
                if (div_stat.done) begin
                    rem_next = div_quot;
                end
            end
            spf_pkg::ST_Q_EMIT: begin
                // Emit one factor, last when nothing remains
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_factor_next = p_reg;
                    m_status_next = spf_pkg::STAT_FACTOR;
                    m_last_next   = rem_reg <= VW'(1);
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= spf_pkg::ST_IDLE;
            limit_reg       <= 16'hFFFF;
            table_valid_reg <= 1'b0;
            built_bound_reg <= '0;
            rem_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            limit_reg       <= limit_next;
            table_valid_reg <= table_valid_next;
            built_bound_reg <= built_bound_next;
            rem_reg         <= rem_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
        bound_reg    <= bound_next;
        i_reg        <= i_next;
        sq_reg       <= sq_next;
        j_reg        <= j_next;
        pend_j_reg   <= pend_j_next;
        p_reg        <= p_next;
        stat_reg     <= stat_next;
        m_factor_reg <= m_factor_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready   = state_reg == spf_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_factor  = m_factor_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

endmodule
